// ===== design/symmetric_fir_filter_defines.svh =====
`ifndef SYMMETRIC_FIR_FILTER_DEFINES_SVH
`define SYMMETRIC_FIR_FILTER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define SFIR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SFIR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/sfir_pkg.sv =====
package sfir_pkg;

  localparam int MAX_HALF_TAPS = 7;
  localparam int SAMPLE_WIDTH = 16;
  localparam int K_W = 3;
  localparam int COEF_W = 17;
  localparam int NUM_COEFS = 7;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 17;
  localparam int FRAC_BITS = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_HALF_TAPS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_CENTER = 3'd1;

  localparam logic [K_W-1:0] HALF_TAPS_RESET = 3'd1;
  localparam logic [COEF_W-1:0] COEF_CENTER_RESET = 17'h10000;

  typedef logic [NUM_COEFS-1:0][COEF_W-1:0] coef_arr_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } shift_ctl_t;

  typedef struct packed {
    logic valid;
    logic last;
  } res_tag_t;

  function automatic logic [K_W-1:0] clamp_half_taps(logic [K_W-1:0] raw, int max_k);
    logic [K_W-1:0] k;
    if (raw == '0) begin
      k = K_W'(1);
    end else if (int'(raw) > max_k) begin
      k = K_W'(max_k);
    end else begin
      k = raw;
    end
    return k;
  endfunction

  // Weight seen by the tap at position pos when the window is centred on position k-1.
  function automatic logic [COEF_W-1:0] tap_coef(int pos, logic [K_W-1:0] k, coef_arr_t coefs);
    int centre;
    int distance;
    logic [COEF_W-1:0] c;
    centre = int'(k) - 1;
    distance = (pos >= centre) ? pos - centre : centre - pos;
    if (pos > 2 * centre) begin
      c = '0;
    end else begin
      c = coefs[distance[K_W-1:0]];
    end
    return c;
  endfunction

endpackage

// ===== design/symmetric_fir_filter.sv =====
// Throughput: one sample per cycle while sample_ready is high; a stream end with K above one
// then shifts K-1 zeros in as a flush and takes no sample meanwhile. The products, the adder
// tree levels and result queue are registered between a window's last sample and its result.
// An 8-entry result queue decouples the tap chain from result backpressure.
// Reset is synchronous: it clears the delay line, fill count and queue, and sets K to 1
// with a unity centre weight and zero side weights.
module symmetric_fir_filter #(
  parameter int MAX_HALF_TAPS = sfir_pkg::MAX_HALF_TAPS,
  parameter int SAMPLE_WIDTH = sfir_pkg::SAMPLE_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   sample_valid,
  output logic                                   sample_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]         sample_in,
  input  logic                                   stream_end,
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output logic signed [SAMPLE_WIDTH-1:0]         sample_out,
  output logic                                   final_out,
  output logic                                   clipped,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sfir_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [sfir_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int K_W = sfir_pkg::K_W;
  localparam int LINE_DEPTH = 2 * MAX_HALF_TAPS - 1;
  localparam int PROD_W = SAMPLE_WIDTH + sfir_pkg::COEF_W;
  localparam int SUM_W = PROD_W + $clog2(LINE_DEPTH) + 1;
  localparam int TREE_LEVELS = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int QUEUE_DEPTH = 2 ** $clog2(TREE_LEVELS + 4);
  localparam int CREDIT_W = $clog2(QUEUE_DEPTH + 1);

  logic [K_W-1:0]                 half_taps;
  logic [K_W-1:0]                 half_taps_next;
  sfir_pkg::coef_arr_t            coefs;
  sfir_pkg::coef_arr_t            coefs_next;
  logic [K_W-1:0]                 fill_count;
  logic                           flushing;
  logic [K_W-1:0]                 flush_left;
  logic [K_W-1:0]                 flush_pending;
  logic [CREDIT_W-1:0]            outstanding;
  sfir_pkg::res_tag_t             tag;
  sfir_pkg::res_tag_t             tag_next;
  sfir_pkg::res_tag_t             tree_tag;
  sfir_pkg::shift_ctl_t           ctl;

  logic [K_W-1:0]                 k_m1;
  logic                           full_win;
  logic                           is_k1;
  logic                           credit_ok;
  logic                           accept;
  logic                           flush_emit;
  logic                           flush_step;
  logic                           flush_last;
  logic                           emit;
  logic                           pop;
  logic signed [SAMPLE_WIDTH-1:0] line_in;
  logic signed [SAMPLE_WIDTH-1:0] taps [LINE_DEPTH];
  logic signed [PROD_W-1:0]       prods [LINE_DEPTH];
  logic signed [SUM_W-1:0]        sum;

  assign cfg_ready = 1'b1;

  always_comb begin
    half_taps_next = half_taps;
    coefs_next = coefs;
    if (rst) begin
      half_taps_next = sfir_pkg::HALF_TAPS_RESET;
      coefs_next = '0;
      coefs_next[0] = sfir_pkg::COEF_CENTER_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sfir_pkg::REG_HALF_TAPS: begin
          half_taps_next = sfir_pkg::clamp_half_taps(cfg_data[K_W-1:0], MAX_HALF_TAPS);
        end
        default: begin
          coefs_next[cfg_index - sfir_pkg::REG_COEF_CENTER] = cfg_data[sfir_pkg::COEF_W-1:0];
        end
      endcase
    end
  end

  assign k_m1 = half_taps - K_W'(1);
  assign full_win = (fill_count >= k_m1);
  assign is_k1 = (half_taps == K_W'(1));
  assign credit_ok = (outstanding < CREDIT_W'(QUEUE_DEPTH));
  assign sample_ready = !flushing && (credit_ok || !full_win);
  assign accept = sample_valid && sample_ready;

  // Flushing shifts K-1 zeros in; only the last flush_pending of them yield results.
  assign flush_emit = (flush_left <= flush_pending);
  assign flush_step = flushing && (credit_ok || !flush_emit);
  assign flush_last = (flush_left == K_W'(1));
  assign emit = (accept && full_win) || (flush_step && flush_emit);
  assign pop = result_valid && result_ready;

  always_comb begin
    ctl.shift = accept || flush_step;
    ctl.clear = (accept && stream_end && is_k1) || (flush_step && flush_last);
    tag_next.valid = emit;
    tag_next.last = flushing ? flush_last : (stream_end && is_k1);
  end

  assign line_in = flushing ? '0 : sample_in;

  always_ff @(posedge clk) begin
    half_taps <= half_taps_next;
    coefs <= coefs_next;
    if (rst) begin
      fill_count <= '0;
      flushing <= 1'b0;
      flush_left <= '0;
      flush_pending <= '0;
      outstanding <= '0;
      tag <= '0;
    end else begin
      tag <= tag_next;
      outstanding <= outstanding + CREDIT_W'(emit) - CREDIT_W'(pop);
      if (accept) begin
        if (stream_end) begin
          fill_count <= '0;
          if (!is_k1) begin
            flushing <= 1'b1;
            flush_left <= k_m1;
            flush_pending <= full_win ? k_m1 : fill_count + K_W'(1);
          end
        end else if (!full_win) begin
          fill_count <= fill_count + K_W'(1);
        end
      end
      if (flush_step) begin
        flush_left <= flush_left - K_W'(1);
        if (flush_last) begin
          flushing <= 1'b0;
        end
      end
    end
  end

  for (genvar p = 0; p < LINE_DEPTH; p++) begin : g_tap
    logic signed [SAMPLE_WIDTH-1:0] din;
    if (p == 0) begin : g_head
      assign din = line_in;
    end else begin : g_body
      assign din = taps[p-1];
    end
    sfir_tap_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .POS(p)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .ctl(ctl),
      .din(din),
      .k_next(half_taps_next),
      .coefs_next(coefs_next),
      .dout(taps[p]),
      .prod(prods[p])
    );
  end

  sfir_adder_tree #(
    .NUM_LEAVES(LINE_DEPTH),
    .IN_W(PROD_W),
    .OUT_W(SUM_W)
  ) u_tree (
    .clk(clk),
    .rst(rst),
    .tag_in(tag),
    .leaf(prods),
    .sum(sum),
    .tag_out(tree_tag)
  );

  sfir_out_queue #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .SUM_W(SUM_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .sum(sum),
    .tag(tree_tag),
    .result_ready(result_ready),
    .result_valid(result_valid),
    .sample_out(sample_out),
    .final_out(final_out),
    .clipped(clipped)
  );

endmodule

// ===== design/sfir_tap_cell.sv =====
module sfir_tap_cell #(
  parameter int SAMPLE_WIDTH = sfir_pkg::SAMPLE_WIDTH,
  parameter int POS = 0,
  localparam int PROD_W = SAMPLE_WIDTH + sfir_pkg::COEF_W
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sfir_pkg::shift_ctl_t              ctl,
  input  logic signed [SAMPLE_WIDTH-1:0]    din,
  input  logic [sfir_pkg::K_W-1:0]          k_next,
  input  sfir_pkg::coef_arr_t               coefs_next,
  output logic signed [SAMPLE_WIDTH-1:0]    dout,
  output logic signed [PROD_W-1:0]          prod
);

  logic [sfir_pkg::COEF_W-1:0] coef;
  logic signed [SAMPLE_WIDTH+sfir_pkg::COEF_W:0] full;

  // The product is taken from the sample entering this tap, so it matches the shifted line.
  assign full = din * $signed({1'b0, coef});

  always_ff @(posedge clk) begin
    if (rst || (ctl.shift && ctl.clear)) begin
      dout <= '0;
    end else if (ctl.shift) begin
      dout <= din;
    end
    coef <= sfir_pkg::tap_coef(POS, k_next, coefs_next);
    prod <= full[PROD_W-1:0];
  end

endmodule

// ===== design/sfir_adder_tree.sv =====
module sfir_adder_tree #(
  parameter int NUM_LEAVES = 13,
  parameter int IN_W = 33,
  parameter int OUT_W = 37
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sfir_pkg::res_tag_t       tag_in,
  input  logic signed [IN_W-1:0]   leaf [NUM_LEAVES],
  output logic signed [OUT_W-1:0]  sum,
  output sfir_pkg::res_tag_t       tag_out
);

  localparam int LEVELS = (NUM_LEAVES > 1) ? $clog2(NUM_LEAVES) : 1;
  localparam int PAD = 2 ** LEVELS;
  localparam int NODES = PAD - 1;

  logic signed [OUT_W-1:0] pad_leaf [PAD];
  logic signed [OUT_W-1:0] node [NODES];
  sfir_pkg::res_tag_t      tag_pipe [LEVELS];

  for (genvar l = 0; l < PAD; l++) begin : g_leaf
    if (l < NUM_LEAVES) begin : g_used
      assign pad_leaf[l] = OUT_W'(leaf[l]);
    end else begin : g_pad
      assign pad_leaf[l] = '0;
    end
  end

  for (genvar i = 0; i < NODES; i++) begin : g_node
    if (2 * i + 1 >= NODES) begin : g_bottom
      always_ff @(posedge clk) begin
        node[i] <= pad_leaf[2*i+1-NODES] + pad_leaf[2*i+2-NODES];
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        node[i] <= node[2*i+1] + node[2*i+2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < LEVELS; j++) begin
        tag_pipe[j] <= '0;
      end
    end else begin
      tag_pipe[0] <= tag_in;
      for (int j = 1; j < LEVELS; j++) begin
        tag_pipe[j] <= tag_pipe[j-1];
      end
    end
  end

  assign sum = node[0];
  assign tag_out = tag_pipe[LEVELS-1];

endmodule

// ===== design/sfir_out_queue.sv =====
module sfir_out_queue #(
  parameter int SAMPLE_WIDTH = sfir_pkg::SAMPLE_WIDTH,
  parameter int SUM_W = 37,
  parameter int DEPTH = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic signed [SUM_W-1:0]         sum,
  input  sfir_pkg::res_tag_t              tag,
  input  logic                            result_ready,
  output logic                            result_valid,
  output logic signed [SAMPLE_WIDTH-1:0]  sample_out,
  output logic                            final_out,
  output logic                            clipped
);

  localparam int RW = SUM_W + 1 - sfir_pkg::FRAC_BITS;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic signed [SUM_W:0] HALF_LSB = (SUM_W + 1)'(2 ** (sfir_pkg::FRAC_BITS - 1));
  localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last;
    logic                           clip;
  } entry_t;

  logic signed [SUM_W:0]         biased;
  logic signed [RW-1:0]          rounded;
  logic [RW-SAMPLE_WIDTH:0]      high;
  logic                          clip;
  entry_t                        entry_in;
  entry_t                        head;
  entry_t                        mem [DEPTH];
  logic [PTR_W-1:0]              wr_ptr;
  logic [PTR_W-1:0]              rd_ptr;
  logic [CNT_W-1:0]              count;
  logic                          pop;

  // Round half up, then saturate when the sign bit and the bits above it disagree.
  assign biased = (SUM_W + 1)'(sum) + HALF_LSB;
  assign rounded = biased[SUM_W:sfir_pkg::FRAC_BITS];
  assign high = rounded[RW-1:SAMPLE_WIDTH-1];
  assign clip = (|high) && !(&high);

  always_comb begin
    entry_in.sample = clip ? (rounded[RW-1] ? SAT_MIN : SAT_MAX) : rounded[SAMPLE_WIDTH-1:0];
    entry_in.last = tag.last;
    entry_in.clip = clip;
  end

  always_ff @(posedge clk) begin
    if (tag.valid) begin
      mem[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (tag.valid) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(tag.valid) - CNT_W'(pop);
    end
  end

  assign head = mem[rd_ptr];
  assign result_valid = (count != '0);
  assign pop = result_valid && result_ready;
  assign sample_out = head.sample;
  assign final_out = head.last;
  assign clipped = head.clip;

endmodule

// ===== design/sfir_checker.sv =====
`include "symmetric_fir_filter_defines.svh"

module sfir_checker #(
  parameter int SAMPLE_WIDTH = sfir_pkg::SAMPLE_WIDTH
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            sample_ready,
  input logic                            result_valid,
  input logic                            result_ready,
  input logic signed [SAMPLE_WIDTH-1:0]  sample_out,
  input logic                            final_out,
  input logic                            clipped
);

  localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

  `SFIR_ASSERT_ALWAYS(a_reset_state, rst |=> (!result_valid && sample_ready), "not empty and ready after reset")
  `SFIR_ASSERT(a_clip_at_limit, (result_valid && clipped) |-> (sample_out == SAT_MAX || sample_out == SAT_MIN), "clipped result is not at a limit")
  `SFIR_ASSERT(a_result_held, (result_valid && !result_ready) |=> (result_valid && $stable(sample_out) && $stable(final_out) && $stable(clipped)), "stalled result changed")

endmodule

bind symmetric_fir_filter sfir_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_checker (
  .clk(clk),
  .rst(rst),
  .sample_ready(sample_ready),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .sample_out(sample_out),
  .final_out(final_out),
  .clipped(clipped)
);
